@@ hdl/cct_pkg.sv @@
// ----------------------------------------------------------------------------
// cct_pkg
// Widths and shared types for the circumcircle point test pipeline.
// ----------------------------------------------------------------------------
package cct_pkg;

	localparam int COORD_WIDTH = 16;

	// coordinate differences
	localparam int DIFF_W  = COORD_WIDTH + 1;
	// squares and squared norms
	localparam int SQ_W    = 2 * COORD_WIDTH;
	localparam int NORM_W  = 2 * COORD_WIDTH + 1;
	localparam int NQ_W    = 2 * COORD_WIDTH + 2;
	// determinant
	localparam int DPROD_W = COORD_WIDTH + DIFF_W;
	localparam int DET_W   = 2 * COORD_WIDTH + 3;
	// centre numerators
	localparam int NPROD_W = NORM_W + DIFF_W;
	localparam int NUM_W   = 3 * COORD_WIDTH + 4;
	// divider operands: numerator magnitude and magnitude of 2D
	localparam int MAG_W   = 3 * COORD_WIDTH + 2;
	localparam int DMAG_W  = 2 * COORD_WIDTH + 2;
	// signed centre coordinate and split for the distance products
	localparam int U_W     = MAG_W + 1;
	localparam int LO_W    = MAG_W / 2;
	localparam int PLO_W   = LO_W + 1 + DIFF_W;
	localparam int PHI_W   = U_W - LO_W + DIFF_W;
	localparam int TERM_W  = U_W + DIFF_W + 2;
	localparam int RES_W   = TERM_W + 2;

	// cycles from the start edge to the edge that takes the result
	localparam int LATENCY = MAG_W + 9;

	typedef struct packed {
		logic                     deg;
		logic                     negx;
		logic                     negy;
		logic signed [DIFF_W-1:0] qdx;
		logic signed [DIFF_W-1:0] qdy;
		logic signed [NQ_W-1:0]   nqa;
	} side_t;

endpackage

@@ hdl/cct_div_pipe.sv @@
// ----------------------------------------------------------------------------
// cct_div_pipe
// Pipelined restoring divider for both centre coordinates, one quotient bit
// per stage, sharing one divisor and carrying side data alongside.
// ----------------------------------------------------------------------------
module cct_div_pipe (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [cct_pkg::MAG_W-1:0]    in_nx,
	input  logic [cct_pkg::MAG_W-1:0]    in_ny,
	input  logic [cct_pkg::DMAG_W-1:0]   in_d,
	input  cct_pkg::side_t               in_side,
	output logic                         out_valid,
	output logic [cct_pkg::MAG_W-1:0]    out_qx,
	output logic [cct_pkg::MAG_W-1:0]    out_qy,
	output cct_pkg::side_t               out_side
);

	localparam int N  = cct_pkg::MAG_W;
	localparam int DW = cct_pkg::DMAG_W;

	logic          vld_s   [N];
	logic [DW-1:0] remx_s  [N];
	logic [DW-1:0] remy_s  [N];
	// numerator bits shift out at the top, quotient bits shift in at the bottom
	logic [N-1:0]  nqx_s   [N];
	logic [N-1:0]  nqy_s   [N];
	logic [DW-1:0] dvs_s   [N];
	cct_pkg::side_t sd_s   [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic          v_in;
		logic [DW-1:0] rx_in, ry_in, d_in;
		logic [N-1:0]  nx_in, ny_in;
		cct_pkg::side_t s_in;
		logic [DW:0]   shx, shy;
		logic          gex, gey;
		logic [DW:0]   subx, suby;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign rx_in = '0;
			assign ry_in = '0;
			assign nx_in = in_nx;
			assign ny_in = in_ny;
			assign d_in  = in_d;
			assign s_in  = in_side;
		end else begin : g_next
			assign v_in  = vld_s[k-1];
			assign rx_in = remx_s[k-1];
			assign ry_in = remy_s[k-1];
			assign nx_in = nqx_s[k-1];
			assign ny_in = nqy_s[k-1];
			assign d_in  = dvs_s[k-1];
			assign s_in  = sd_s[k-1];
		end

		assign shx  = {rx_in, nx_in[N-1]};
		assign shy  = {ry_in, ny_in[N-1]};
		assign gex  = shx >= {1'b0, d_in};
		assign gey  = shy >= {1'b0, d_in};
		assign subx = shx - {1'b0, d_in};
		assign suby = shy - {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			remx_s[k] <= gex ? subx[DW-1:0] : shx[DW-1:0];
			remy_s[k] <= gey ? suby[DW-1:0] : shy[DW-1:0];
			nqx_s[k]  <= {nx_in[N-2:0], gex};
			nqy_s[k]  <= {ny_in[N-2:0], gey};
			dvs_s[k]  <= d_in;
			sd_s[k]   <= s_in;
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_qx    = nqx_s[N-1];
	assign out_qy    = nqy_s[N-1];
	assign out_side  = sd_s[N-1];

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[N-1] && dvs_s[N-1] != '0) |-> (remx_s[N-1] < dvs_s[N-1] &&
			remy_s[N-1] < dvs_s[N-1]))
		else $error("divider remainder not below divisor");

	a_valid_delay: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##(N) out_valid)
		else $error("divider lost a transfer");

	a_side_delay: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##(N) (out_side == $past(in_side, N)))
		else $error("divider side data out of step");

endmodule

@@ hdl/circumcircle_point_test.sv @@
// ----------------------------------------------------------------------------
// circumcircle_point_test
// Incircle test of a query point against the circumcircle of a triangle.
// ----------------------------------------------------------------------------
// Usage: drive the eight signed coordinates and raise start; a transfer takes
// place at each rising edge where start is high and busy is low. busy stays
// low, so a new triangle may be given every cycle.
// Each transfer yields one result: done is high for exactly one cycle with
// inside_res (query within or on the circle) and degenerate (collinear
// vertices, inside_res then 0). The receiver cannot hold results off; done
// rises once the result has passed the bit-per-stage divider of 50 stages
// and nine arithmetic stages (LATENCY in the package holds the total).
// Throughput is one item per cycle. Reset clears all valid bits, so no
// result appears for items in flight at reset.
// ----------------------------------------------------------------------------
module circumcircle_point_test (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [cct_pkg::COORD_WIDTH-1:0]  vertex_a_x,
	input  logic signed [cct_pkg::COORD_WIDTH-1:0]  vertex_a_y,
	input  logic signed [cct_pkg::COORD_WIDTH-1:0]  vertex_b_x,
	input  logic signed [cct_pkg::COORD_WIDTH-1:0]  vertex_b_y,
	input  logic signed [cct_pkg::COORD_WIDTH-1:0]  vertex_c_x,
	input  logic signed [cct_pkg::COORD_WIDTH-1:0]  vertex_c_y,
	input  logic signed [cct_pkg::COORD_WIDTH-1:0]  query_x,
	input  logic signed [cct_pkg::COORD_WIDTH-1:0]  query_y,
	output logic                                    done,
	output logic                                    inside_res,
	output logic                                    degenerate
);

	localparam int W = cct_pkg::COORD_WIDTH;

	// stage 1: squares and differences
	logic                                 v_s1;
	logic signed [W-1:0]                  ax_s1, bx_s1, cx_s1;
	logic signed [cct_pkg::SQ_W-1:0]      axx_s1, ayy_s1, bxx_s1, byy_s1, cxx_s1, cyy_s1;
	logic signed [cct_pkg::SQ_W-1:0]      qxx_s1, qyy_s1;
	logic signed [cct_pkg::DIFF_W-1:0]    dycb_s1, dyac_s1, dyba_s1;
	logic signed [cct_pkg::DIFF_W-1:0]    dxcb_s1, dxac_s1, dxba_s1;
	logic signed [cct_pkg::DIFF_W-1:0]    qdx_s1, qdy_s1;

	// stage 2: norms and determinant products
	logic                                 v_s2;
	logic signed [cct_pkg::NORM_W-1:0]    na_s2, nb_s2, nc_s2;
	logic signed [cct_pkg::NQ_W-1:0]      nqa_s2;
	logic signed [cct_pkg::DPROD_W-1:0]   pd0_s2, pd1_s2, pd2_s2;
	logic signed [cct_pkg::DIFF_W-1:0]    dycb_s2, dyac_s2, dyba_s2;
	logic signed [cct_pkg::DIFF_W-1:0]    dxcb_s2, dxac_s2, dxba_s2;
	logic signed [cct_pkg::DIFF_W-1:0]    qdx_s2, qdy_s2;

	// stage 3: determinant and numerator products
	logic                                 v_s3;
	logic signed [cct_pkg::DET_W-1:0]     det_s3;
	logic signed [cct_pkg::NPROD_W-1:0]   px0_s3, px1_s3, px2_s3, py0_s3, py1_s3, py2_s3;
	logic signed [cct_pkg::NQ_W-1:0]      nqa_s3;
	logic signed [cct_pkg::DIFF_W-1:0]    qdx_s3, qdy_s3;

	// stage 4: numerators
	logic                                 v_s4;
	logic signed [cct_pkg::DET_W-1:0]     det_s4;
	logic signed [cct_pkg::NUM_W-1:0]     numx_s4, numy_s4;
	logic signed [cct_pkg::NQ_W-1:0]      nqa_s4;
	logic signed [cct_pkg::DIFF_W-1:0]    qdx_s4, qdy_s4;

	// stage 5: magnitudes and quotient signs into the divider
	logic                                 v_s5;
	logic [cct_pkg::MAG_W-1:0]            nmx_s5, nmy_s5;
	logic [cct_pkg::DMAG_W-1:0]           dmag_s5;
	cct_pkg::side_t                       side_s5;

	logic signed [cct_pkg::NUM_W-1:0]     absx, absy;
	logic signed [cct_pkg::DET_W-1:0]     absd;

	// divider outputs
	logic                                 dv_valid;
	logic [cct_pkg::MAG_W-1:0]            dv_qx, dv_qy;
	cct_pkg::side_t                       dv_side;

	// stage 6..8: centre, distance products, sum
	logic                                 v_s6, v_s7, v_s8;
	logic signed [cct_pkg::U_W-1:0]       ux_s6, uy_s6;
	cct_pkg::side_t                       side_s6, side_s7, side_s8;
	logic signed [cct_pkg::PLO_W-1:0]     plox_s7, ploy_s7;
	logic signed [cct_pkg::PHI_W-1:0]     phix_s7, phiy_s7;
	logic signed [cct_pkg::TERM_W-1:0]    term_s8;
	logic signed [cct_pkg::RES_W-1:0]     diff;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= dv_valid;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			done <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1   <= vertex_a_x;
		bx_s1   <= vertex_b_x;
		cx_s1   <= vertex_c_x;
		axx_s1  <= cct_pkg::SQ_W'(vertex_a_x) * cct_pkg::SQ_W'(vertex_a_x);
		ayy_s1  <= cct_pkg::SQ_W'(vertex_a_y) * cct_pkg::SQ_W'(vertex_a_y);
		bxx_s1  <= cct_pkg::SQ_W'(vertex_b_x) * cct_pkg::SQ_W'(vertex_b_x);
		byy_s1  <= cct_pkg::SQ_W'(vertex_b_y) * cct_pkg::SQ_W'(vertex_b_y);
		cxx_s1  <= cct_pkg::SQ_W'(vertex_c_x) * cct_pkg::SQ_W'(vertex_c_x);
		cyy_s1  <= cct_pkg::SQ_W'(vertex_c_y) * cct_pkg::SQ_W'(vertex_c_y);
		qxx_s1  <= cct_pkg::SQ_W'(query_x) * cct_pkg::SQ_W'(query_x);
		qyy_s1  <= cct_pkg::SQ_W'(query_y) * cct_pkg::SQ_W'(query_y);
		dycb_s1 <= cct_pkg::DIFF_W'(vertex_c_y) - cct_pkg::DIFF_W'(vertex_b_y);
		dyac_s1 <= cct_pkg::DIFF_W'(vertex_a_y) - cct_pkg::DIFF_W'(vertex_c_y);
		dyba_s1 <= cct_pkg::DIFF_W'(vertex_b_y) - cct_pkg::DIFF_W'(vertex_a_y);
		dxcb_s1 <= cct_pkg::DIFF_W'(vertex_c_x) - cct_pkg::DIFF_W'(vertex_b_x);
		dxac_s1 <= cct_pkg::DIFF_W'(vertex_a_x) - cct_pkg::DIFF_W'(vertex_c_x);
		dxba_s1 <= cct_pkg::DIFF_W'(vertex_b_x) - cct_pkg::DIFF_W'(vertex_a_x);
		qdx_s1  <= cct_pkg::DIFF_W'(query_x) - cct_pkg::DIFF_W'(vertex_a_x);
		qdy_s1  <= cct_pkg::DIFF_W'(query_y) - cct_pkg::DIFF_W'(vertex_a_y);

		na_s2   <= cct_pkg::NORM_W'(axx_s1) + cct_pkg::NORM_W'(ayy_s1);
		nb_s2   <= cct_pkg::NORM_W'(bxx_s1) + cct_pkg::NORM_W'(byy_s1);
		nc_s2   <= cct_pkg::NORM_W'(cxx_s1) + cct_pkg::NORM_W'(cyy_s1);
		nqa_s2  <= cct_pkg::NQ_W'(qxx_s1) + cct_pkg::NQ_W'(qyy_s1)
			- cct_pkg::NQ_W'(axx_s1) - cct_pkg::NQ_W'(ayy_s1);
		pd0_s2  <= cct_pkg::DPROD_W'(ax_s1) * cct_pkg::DPROD_W'(dycb_s1);
		pd1_s2  <= cct_pkg::DPROD_W'(bx_s1) * cct_pkg::DPROD_W'(dyac_s1);
		pd2_s2  <= cct_pkg::DPROD_W'(cx_s1) * cct_pkg::DPROD_W'(dyba_s1);
		dycb_s2 <= dycb_s1;
		dyac_s2 <= dyac_s1;
		dyba_s2 <= dyba_s1;
		dxcb_s2 <= dxcb_s1;
		dxac_s2 <= dxac_s1;
		dxba_s2 <= dxba_s1;
		qdx_s2  <= qdx_s1;
		qdy_s2  <= qdy_s1;

		det_s3  <= cct_pkg::DET_W'(pd0_s2) + cct_pkg::DET_W'(pd1_s2)
			+ cct_pkg::DET_W'(pd2_s2);
		px0_s3  <= cct_pkg::NPROD_W'(na_s2) * cct_pkg::NPROD_W'(dycb_s2);
		px1_s3  <= cct_pkg::NPROD_W'(nb_s2) * cct_pkg::NPROD_W'(dyac_s2);
		px2_s3  <= cct_pkg::NPROD_W'(nc_s2) * cct_pkg::NPROD_W'(dyba_s2);
		py0_s3  <= cct_pkg::NPROD_W'(na_s2) * cct_pkg::NPROD_W'(dxcb_s2);
		py1_s3  <= cct_pkg::NPROD_W'(nb_s2) * cct_pkg::NPROD_W'(dxac_s2);
		py2_s3  <= cct_pkg::NPROD_W'(nc_s2) * cct_pkg::NPROD_W'(dxba_s2);
		nqa_s3  <= nqa_s2;
		qdx_s3  <= qdx_s2;
		qdy_s3  <= qdy_s2;

		det_s4  <= det_s3;
		numx_s4 <= cct_pkg::NUM_W'(px0_s3) + cct_pkg::NUM_W'(px1_s3)
			+ cct_pkg::NUM_W'(px2_s3);
		numy_s4 <= cct_pkg::NUM_W'(py0_s3) + cct_pkg::NUM_W'(py1_s3)
			+ cct_pkg::NUM_W'(py2_s3);
		nqa_s4  <= nqa_s3;
		qdx_s4  <= qdx_s3;
		qdy_s4  <= qdy_s3;
	end

	assign absx = numx_s4[cct_pkg::NUM_W-1] ? -numx_s4 : numx_s4;
	assign absy = numy_s4[cct_pkg::NUM_W-1] ? -numy_s4 : numy_s4;
	assign absd = det_s4[cct_pkg::DET_W-1] ? -det_s4 : det_s4;

	always_ff @(posedge clk) begin
		nmx_s5       <= absx[cct_pkg::MAG_W-1:0];
		nmy_s5       <= absy[cct_pkg::MAG_W-1:0];
		dmag_s5      <= {absd[cct_pkg::DMAG_W-2:0], 1'b0};
		side_s5.deg  <= det_s4 == '0;
		// y centre divides by -2D, so its sign flips
		side_s5.negx <= numx_s4[cct_pkg::NUM_W-1] ^ det_s4[cct_pkg::DET_W-1];
		side_s5.negy <= numy_s4[cct_pkg::NUM_W-1] ^ ~det_s4[cct_pkg::DET_W-1];
		side_s5.qdx  <= qdx_s4;
		side_s5.qdy  <= qdy_s4;
		side_s5.nqa  <= nqa_s4;
	end

	cct_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_nx     (nmx_s5),
		.in_ny     (nmy_s5),
		.in_d      (dmag_s5),
		.in_side   (side_s5),
		.out_valid (dv_valid),
		.out_qx    (dv_qx),
		.out_qy    (dv_qy),
		.out_side  (dv_side)
	);

	// |q-u|^2 - |a-u|^2 = |q|^2 - |a|^2 - 2 u.(q-a)
	always_ff @(posedge clk) begin
		ux_s6   <= dv_side.negx ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
		uy_s6   <= dv_side.negy ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
		side_s6 <= dv_side;

		plox_s7 <= cct_pkg::PLO_W'($signed({1'b0, ux_s6[cct_pkg::LO_W-1:0]}))
			* cct_pkg::PLO_W'(side_s6.qdx);
		ploy_s7 <= cct_pkg::PLO_W'($signed({1'b0, uy_s6[cct_pkg::LO_W-1:0]}))
			* cct_pkg::PLO_W'(side_s6.qdy);
		phix_s7 <= cct_pkg::PHI_W'($signed(ux_s6[cct_pkg::U_W-1:cct_pkg::LO_W]))
			* cct_pkg::PHI_W'(side_s6.qdx);
		phiy_s7 <= cct_pkg::PHI_W'($signed(uy_s6[cct_pkg::U_W-1:cct_pkg::LO_W]))
			* cct_pkg::PHI_W'(side_s6.qdy);
		side_s7 <= side_s6;

		term_s8 <= (cct_pkg::TERM_W'(phix_s7) <<< cct_pkg::LO_W) + cct_pkg::TERM_W'(plox_s7)
			+ (cct_pkg::TERM_W'(phiy_s7) <<< cct_pkg::LO_W) + cct_pkg::TERM_W'(ploy_s7);
		side_s8 <= side_s7;
	end

	assign diff = cct_pkg::RES_W'(side_s8.nqa) - (cct_pkg::RES_W'(term_s8) <<< 1);

	always_ff @(posedge clk) begin
		degenerate <= side_s8.deg;
		inside_res <= !side_s8.deg && (diff[cct_pkg::RES_W-1] || diff == '0);
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(cct_pkg::LATENCY) done)
		else $error("transfer produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !v_s8 && !v_s7) |=> !done)
		else $error("result strobe longer than its transfers");

	a_degen_outside: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(inside_res && degenerate))
		else $error("degenerate triangle reported inside");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks circumcircle_point_test against a wide-integer incircle
// predictor, with directed corner triangles and random streams with and without idling.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WW = 192;
	localparam int QUIET_LIMIT = 4000;

	typedef logic signed [WW-1:0] wide_t;
	typedef logic signed [cct_pkg::COORD_WIDTH-1:0] crd_t;

	typedef struct packed {
		logic hit;
		logic deg;
	} verdict_t;

	class incircle_board;
		verdict_t pending[$];
		int errors = 0;

		function void note(verdict_t v);
			pending.push_back(v);
		endfunction

		function void check(logic hit, logic deg);
			verdict_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result inside=%0b degenerate=%0b", $time, hit, deg);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e.hit !== hit) begin
				$display("%0t: inside_res expected %0b actual %0b", $time, e.hit, hit);
				errors++;
			end
			if (e.deg !== deg) begin
				$display("%0t: degenerate expected %0b actual %0b", $time, e.deg, deg);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done, inside_res, degenerate;
	crd_t vertex_a_x = 0, vertex_a_y = 0, vertex_b_x = 0, vertex_b_y = 0;
	crd_t vertex_c_x = 0, vertex_c_y = 0, query_x = 0, query_y = 0;

	incircle_board board = new();
	int quiet = 0;
	bit idling = 1;

	circumcircle_point_test uut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic wide_t rot_sum(wide_t x, wide_t y, wide_t z, wide_t a, wide_t b,
			wide_t c);
		return x * (c - b) + y * (a - c) + z * (b - a);
	endfunction

	function automatic verdict_t predict_incircle(crd_t iax, crd_t iay, crd_t ibx, crd_t iby,
			crd_t icx, crd_t icy, crd_t iqx, crd_t iqy);
		wide_t ax, ay, bx, by, cx, cy, qx, qy;
		wide_t na, nb, nc, dx_, dy_, ux, uy, dq, da;
		verdict_t v;
		ax = iax; ay = iay; bx = ibx; by = iby;
		cx = icx; cy = icy; qx = iqx; qy = iqy;
		na = ax * ax + ay * ay;
		nb = bx * bx + by * by;
		nc = cx * cx + cy * cy;
		dx_ = rot_sum(ax, bx, cx, ay, by, cy);
		dy_ = rot_sum(ay, by, cy, ax, bx, cx);
		if (dx_ == 0 || dy_ == 0) begin
			v.hit = 0;
			v.deg = 1;
			return v;
		end
		// signed division truncates toward zero
		ux = rot_sum(na, nb, nc, ay, by, cy) / (dx_ * 2);
		uy = rot_sum(na, nb, nc, ax, bx, cx) / (dy_ * 2);
		dq = (qx - ux) * (qx - ux) + (qy - uy) * (qy - uy);
		da = (ax - ux) * (ax - ux) + (ay - uy) * (ay - uy);
		v.hit = (dq <= da);
		v.deg = 0;
		return v;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				board.note(predict_incircle(vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
					vertex_c_x, vertex_c_y, query_x, query_y));
			end
			if (done) begin
				board.check(inside_res, degenerate);
			end
			if ((start && !busy) || done) begin
				quiet <= 0;
			end else begin
				quiet <= quiet + 1;
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send(crd_t ax, crd_t ay, crd_t bx, crd_t by, crd_t cx, crd_t cy,
			crd_t qx, crd_t qy);
		if (idling && $urandom_range(99) < 7) begin
			start <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		vertex_a_x <= ax; vertex_a_y <= ay;
		vertex_b_x <= bx; vertex_b_y <= by;
		vertex_c_x <= cx; vertex_c_y <= cy;
		query_x <= qx; query_y <= qy;
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic crd_t small_crd(int span);
		return crd_t'($urandom_range(2 * span) - span);
	endfunction

	task automatic random_item();
		crd_t ax, ay, bx, by, cx, cy, qx, qy, dx, dy;
		int kind, span, s, t;
		kind = $urandom_range(99);
		span = ($urandom_range(3) == 0) ? 32767 : $urandom_range(1, 3000);
		ax = small_crd(span); ay = small_crd(span);
		bx = small_crd(span); by = small_crd(span);
		cx = small_crd(span); cy = small_crd(span);
		qx = small_crd(span); qy = small_crd(span);
		if (kind < 20) begin
			ax = crd_t'($urandom); ay = crd_t'($urandom);
			bx = crd_t'($urandom); by = crd_t'($urandom);
			cx = crd_t'($urandom); cy = crd_t'($urandom);
			qx = crd_t'($urandom); qy = crd_t'($urandom);
		end else if (kind < 35) begin
			// collinear vertices
			dx = small_crd(40); dy = small_crd(40);
			s = $urandom_range(60) - 30; t = $urandom_range(60) - 30;
			ax = small_crd(1000); ay = small_crd(1000);
			bx = crd_t'(ax + s * dx); by = crd_t'(ay + s * dy);
			cx = crd_t'(ax + t * dx); cy = crd_t'(ay + t * dy);
		end else if (kind < 55) begin
			// query on a vertex, on or near the boundary
			case ($urandom_range(2))
				0: begin qx = ax; qy = ay; end
				1: begin qx = bx; qy = by; end
				default: begin qx = cx + small_crd(2); qy = cy + small_crd(2); end
			endcase
		end else if (kind < 65) begin
			// query close to the centre region
			qx = crd_t'((ax + bx + cx) / 3); qy = crd_t'((ay + by + cy) / 3);
		end
		send(ax, ay, bx, by, cx, cy, qx, qy);
	endtask

	initial begin
		crd_t mx, mn;
		mx = 16'sh7fff;
		mn = 16'sh8000;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// corners: extremes, collinear, all equal, boundary and centre queries
		send(0, 0, 0, 0, 0, 0, 0, 0);
		send(mx, mx, mx, mx, mx, mx, mx, mx);
		send(mn, mn, mn, mn, mn, mn, mn, mn);
		send(mn, mn, mx, mn, mn, mx, mx, mx);
		send(mx, mx, mn, mx, mx, mn, mn, mn);
		send(mn, mn, mx, mn, mn, mx, 0, 0);
		send(mn, 0, mx, 0, 0, mx, mn, mn);
		send(0, 0, 256, 0, 0, 256, 0, 0);
		send(0, 0, 256, 0, 0, 256, 256, 256);
		send(0, 0, 256, 0, 0, 256, 257, 256);
		send(0, 0, 256, 0, 0, 256, 128, 128);
		send(0, 0, 1, 0, 0, 1, 1, 1);
		send(0, 0, 1, 0, 2, 0, 0, 0);
		send(mn, mn, 0, 0, mx, mx, 0, 0);
		send(-1, -1, 1, -1, 0, 1, 0, 0);
		send(0, 0, 1, 0, 0, 1, mn, mx);
		send(mx, 0, 0, mx, mn, 0, 0, mn);
		send(mx, 0, 0, mx, mn, 0, mx, mx);
		send(100, 200, 100, 200, 300, 50, 100, 200);
		send(-256, 0, 256, 0, 0, 1, 0, -1);
		for (int i = 0; i < 1600; i++) begin
			idling = !(i >= 600 && i < 1000);
			random_item();
		end
		start <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (cct_pkg::LATENCY + 10) @(posedge clk);
		if (board.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
